@@ src/sef_pkg.sv @@
// Shared types and constants for the streaming Sobel edge filter.
// Used by every module under src; depends on nothing.
package sef_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   localparam int PIX_W = 8;
   localparam int DIM_W = 12;
   localparam int CNT_W = DIM_W + 2;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_LEVEL_W = $clog2(Q_DEPTH + 1);

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = 12'd640;
   localparam logic [DIM_W-1:0] RESET_HEIGHT = 12'd480;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_value;
      logic             is_flush;
   } sef_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] edge_value;
      logic             last_of_frame;
   } sef_rsp_type;

   // masked neighbors that survive the kernel sum (corners top-right and
   // bottom-left cancel out)
   typedef struct packed {
      logic [PIX_W-1:0] up_left;
      logic [PIX_W-1:0] up_mid;
      logic [PIX_W-1:0] mid_left;
      logic [PIX_W-1:0] mid_right;
      logic [PIX_W-1:0] low_mid;
      logic [PIX_W-1:0] low_right;
      logic             last;
   } sef_nbhd_type;

endpackage

@@ src/sef_queue.sv @@
// Short FIFO of neighborhood transactions between front and back end.
// Depends on sef_pkg.
module sef_queue
   import sef_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sef_nbhd_type         push_data,
   input  logic                 pop,
   output sef_nbhd_type         head,
   output logic                 not_empty,
   output logic [Q_LEVEL_W-1:0] level
);

   sef_nbhd_type         entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_LEVEL_W-1:0] level_ff, level_in;

   function automatic logic [Q_PTR_W-1:0] ptr_next(input logic [Q_PTR_W-1:0] p);
      if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
         return '0;
      end
      return p + Q_PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + Q_LEVEL_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - Q_LEVEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (level_ff != '0);
   assign level     = level_ff;

endmodule

@@ src/sef_front.sv @@
// Front end: size registers, raster position, line stores and window.
// Classifies each transaction and pushes the masked neighborhood; depends on sef_pkg.
module sef_front
   import sef_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sef_req_type          req_data,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata,
   input  logic [Q_LEVEL_W-1:0] q_level,
   output logic                 push,
   output sef_nbhd_type         push_data
);

   logic [CNT_W-1:0] width_ff, width_in;
   logic [CNT_W-1:0] height_ff, height_in;
   logic [COL_W-1:0] x_ff, x_in;
   logic [ROW_W-1:0] y_ff, y_in;

   logic [PIX_W-1:0] upper_mem_ff  [MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem_ff [MAX_WIDTH];
   logic [PIX_W-1:0] rd_upper_ff, rd_middle_ff;
   logic             fwd_ff;
   logic [PIX_W-1:0] fwd_upper_ff, fwd_middle_ff;

   logic             s1_valid_ff, s1_emit_ff, s1_case_a_ff, s1_last_ff;
   logic             s1_top_ff, s1_bot_ff, s1_left_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [COL_W-1:0] s1_x_ff;

   logic [PIX_W-1:0] top1_ff, top2_ff, mid1_ff, mid2_ff, bot1_ff, bot2_ff;

   logic             accept;
   logic [Q_LEVEL_W:0] need;
   logic [CNT_W-1:0] xe, ye, xn;
   logic             case_a, case_b, beyond, last, top, bot, left, wrap;
   logic [PIX_W-1:0] pix, cur_a, cur_b;

   function automatic logic [CNT_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [CNT_W-1:0] maxv);
      if (v == '0) begin
         return CNT_W'(1);
      end
      if (CNT_W'(v) > maxv) begin
         return maxv;
      end
      return CNT_W'(v);
   endfunction

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               width_in = clamp_dim(csr_wdata, CNT_W'(MAX_WIDTH));
            end
            CSR_IMAGE_HEIGHT: begin
               height_in = clamp_dim(csr_wdata, CNT_W'(MAX_HEIGHT));
            end
         endcase
      end
   end

   always_comb begin
      need = (Q_LEVEL_W+1)'(q_level) + (Q_LEVEL_W+1)'(s1_valid_ff && s1_emit_ff)
           + (Q_LEVEL_W+1)'(1);
      req_stall = need > (Q_LEVEL_W+1)'(Q_DEPTH);
      accept    = req_valid && !req_stall;

      xe     = CNT_W'(x_ff);
      ye     = CNT_W'(y_ff);
      case_a = (x_ff == '0) && (ye >= CNT_W'(2));
      case_b = (x_ff != '0) && (ye >= CNT_W'(1));
      beyond = ye > height_ff;
      last   = case_a && beyond;
      top    = case_a ? (ye == CNT_W'(2)) : (ye == CNT_W'(1));
      bot    = case_a ? beyond : (ye >= height_ff);
      left   = case_a ? (width_ff == CNT_W'(1)) : (xe == CNT_W'(1));
      xn     = xe + CNT_W'(1);
      wrap   = xn >= width_ff;
      pix    = req_data.is_flush ? '0 : req_data.pixel_value;

      x_in = x_ff;
      y_in = y_ff;
      if (csr_wen) begin
         x_in = '0;
         y_in = '0;
      end else if (accept) begin
         if (last) begin
            x_in = '0;
            y_in = '0;
         end else if (wrap) begin
            x_in = '0;
            y_in = y_ff + ROW_W'(1);
         end else begin
            x_in = x_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= CNT_W'(RESET_WIDTH);
         height_ff   <= CNT_W'(RESET_HEIGHT);
         x_ff        <= '0;
         y_ff        <= '0;
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         x_ff        <= x_in;
         y_ff        <= y_in;
         s1_valid_ff <= accept;
         fwd_ff      <= accept && s1_valid_ff && (s1_x_ff == x_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_emit_ff   <= case_a || case_b;
         s1_case_a_ff <= case_a;
         s1_last_ff   <= last;
         s1_top_ff    <= top;
         s1_bot_ff    <= bot;
         s1_left_ff   <= left;
         s1_pix_ff    <= pix;
         s1_x_ff      <= x_ff;
      end
      fwd_upper_ff  <= cur_b;
      fwd_middle_ff <= s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_upper_ff <= upper_mem_ff[x_ff];
      end
      if (s1_valid_ff) begin
         upper_mem_ff[s1_x_ff] <= cur_b;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_middle_ff <= middle_mem_ff[x_ff];
      end
      if (s1_valid_ff) begin
         middle_mem_ff[s1_x_ff] <= s1_pix_ff;
      end
   end

   assign cur_a = fwd_ff ? fwd_upper_ff  : rd_upper_ff;
   assign cur_b = fwd_ff ? fwd_middle_ff : rd_middle_ff;

   always_ff @(posedge clock) begin
      if (reset || csr_wen) begin
         top1_ff <= '0;
         top2_ff <= '0;
         mid1_ff <= '0;
         mid2_ff <= '0;
         bot1_ff <= '0;
         bot2_ff <= '0;
      end else if (s1_valid_ff) begin
         top1_ff <= top2_ff;
         top2_ff <= cur_a;
         mid1_ff <= mid2_ff;
         mid2_ff <= cur_b;
         bot1_ff <= bot2_ff;
         bot2_ff <= s1_pix_ff;
      end
   end

   always_comb begin
      push                = s1_valid_ff && s1_emit_ff;
      push_data.up_left   = (s1_top_ff || s1_left_ff) ? '0 : top1_ff;
      push_data.up_mid    = s1_top_ff ? '0 : top2_ff;
      push_data.mid_left  = s1_left_ff ? '0 : mid1_ff;
      push_data.mid_right = s1_case_a_ff ? '0 : cur_b;
      push_data.low_mid   = s1_bot_ff ? '0 : bot2_ff;
      push_data.low_right = (s1_case_a_ff || s1_bot_ff) ? '0 : s1_pix_ff;
      push_data.last      = s1_last_ff;
   end

endmodule

@@ src/sef_back.sv @@
// Back end: kernel sum, magnitude and clamp, result register.
// Pops neighborhoods from the queue; depends on sef_pkg.
module sef_back
   import sef_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  sef_nbhd_type head,
   input  logic         not_empty,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output sef_rsp_type  rsp_data
);

   localparam int SUM_W  = PIX_W + 2;
   localparam int DIFF_W = SUM_W + 1;

   logic                     b1_valid_ff, b1_valid_in;
   logic signed [DIFF_W-1:0] b1_diff_ff;
   logic                     b1_last_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   sef_rsp_type              rsp_data_ff;

   logic                     out_free, load_b1;
   logic [SUM_W-1:0]         sum_pos, sum_neg, mag;
   logic signed [DIFF_W-1:0] diff, neg_diff;
   logic [PIX_W-1:0]         edge_val;

   always_comb begin
      sum_pos = SUM_W'(head.mid_right) + SUM_W'(head.low_mid) + SUM_W'(head.low_right);
      sum_neg = SUM_W'(head.up_left) + SUM_W'(head.up_mid) + SUM_W'(head.mid_left);
      diff    = $signed({1'b0, sum_pos}) - $signed({1'b0, sum_neg});

      neg_diff = -b1_diff_ff;
      mag      = b1_diff_ff[DIFF_W-1] ? neg_diff[SUM_W-1:0] : b1_diff_ff[SUM_W-1:0];
      // result is twice the difference: saturate once it leaves 8 bits
      edge_val = (mag > SUM_W'(127)) ? 8'hFF : {mag[PIX_W-2:0], 1'b0};

      out_free     = !rsp_valid_ff || !rsp_stall;
      load_b1      = !b1_valid_ff || out_free;
      pop          = not_empty && load_b1;
      b1_valid_in  = load_b1 ? not_empty : b1_valid_ff;
      rsp_valid_in = out_free ? b1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b1_diff_ff <= diff;
         b1_last_ff <= head.last;
      end
      if (out_free && b1_valid_ff) begin
         rsp_data_ff.edge_value    <= edge_val;
         rsp_data_ff.last_of_frame <= b1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/sobel_edge_filter.sv @@
// Top level of the streaming 3x3 Sobel edge filter.
// Ties sef_front, sef_queue and sef_back together; depends on sef_pkg.
//
//   channel   ports                            direction   moves
//   request   req_valid, req_stall, req_data   in          one pixel or flush
//   response  rsp_valid, rsp_stall, rsp_data   out         one edge value
//   control   csr_wen, csr_index, csr_wdata    in          size register write
//
// Takes one transaction per clock; the front end's line-store read and the
// window update set that pace. Results pass through the front stage, queue,
// difference and result registers. Synchronous reset clears the position,
// window, pipeline and queue; line stores keep their content. A register
// write restarts the frame. A response stall backs up the queue, and the
// request side stalls only when the queue cannot take what is in flight.
module sobel_edge_filter
   import sef_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sef_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sef_rsp_type          rsp_data,
   input  logic                 csr_wen,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DIM_W-1:0]     csr_wdata
);

   logic                 push, pop, not_empty;
   sef_nbhd_type         push_data, head;
   logic [Q_LEVEL_W-1:0] q_level;

   sef_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_level   (q_level),
      .push      (push),
      .push_data (push_data)
   );

   sef_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .level     (q_level)
   );

   sef_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .not_empty (not_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
